// ----- rtl/core/mrt_pkg.sv -----
// Shared types and constants for the MIDI route table mapper.
// No dependencies; imported by all block files but mrt_if.
package mrt_pkg;

  localparam logic [1:0] ACT_ROUTE  = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [7:0] STATUS_KIND_MASK = 8'hF0;
  localparam logic [7:0] STATUS_CHAN_MASK = 8'h0F;
  localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
  localparam logic [7:0] STATUS_CONTROL   = 8'hB0;
  localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
  localparam logic [7:0] STATUS_BEND      = 8'hE0;

  localparam logic [6:0] NOTE_MAX   = 7'd127;
  localparam logic [4:0] IN_CH_ANY  = 5'h1F;
  localparam logic [15:0] GAIN_UNITY = 16'd256;

  localparam logic [2:0] EV_NOTE_ON  = 3'd0;
  localparam logic [2:0] EV_NOTE_OFF = 3'd1;
  localparam logic [2:0] EV_CONTROL  = 3'd2;
  localparam logic [2:0] EV_PROGRAM  = 3'd3;
  localparam logic [2:0] EV_BEND     = 3'd4;

  localparam int unsigned LIMIT_W   = 4;
  localparam logic [LIMIT_W-1:0] MAX_RESULTS = 4'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ROUTE,
    OP_ADD,
    OP_REMOVE
  } op_e;

  typedef enum logic [2:0] {
    KIND_NOTE_ON,
    KIND_NOTE_OFF,
    KIND_CONTROL,
    KIND_PROGRAM,
    KIND_BEND
  } kind_e;

  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [3:0]  chan;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [7:0]  track;
    logic [4:0]  in_ch;
    logic [3:0]  out_ch;
    logic [7:0]  transpose;
    logic [6:0]  min_note;
    logic [6:0]  max_note;
    logic [15:0] gain;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  out_channel;
    logic [6:0]  out_note;
    logic [6:0]  out_velocity;
    logic [6:0]  out_controller;
    logic [13:0] out_value;
    logic        last_of_run;
  } res_t;

endpackage

// ----- rtl/core/mrt_if.sv -----
// Handshake interfaces for the message input and the result output channels.
// No dependencies on the package; payload widths are those of the channel fields.
interface mrt_msg_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        msg_status;
  logic [6:0]        msg_data1;
  logic [6:0]        msg_data2;
  logic [7:0]        track_id;
  logic signed [4:0] new_in_channel;
  logic [3:0]        new_out_channel;
  logic signed [7:0] new_transpose;
  logic [6:0]        new_min_note;
  logic [6:0]        new_max_note;
  logic [15:0]       new_velocity_gain;

  modport source (
    output valid, action, msg_status, msg_data1, msg_data2, track_id, new_in_channel,
           new_out_channel, new_transpose, new_min_note, new_max_note, new_velocity_gain,
    input  ready
  );
  modport sink (
    input  valid, action, msg_status, msg_data1, msg_data2, track_id, new_in_channel,
           new_out_channel, new_transpose, new_min_note, new_max_note, new_velocity_gain,
    output ready
  );
endinterface

interface mrt_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [3:0]  out_channel;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [6:0]  out_controller;
  logic [13:0] out_value;
  logic        last_of_run;

  modport source (
    output valid, event_kind, out_channel, out_note, out_velocity, out_controller,
           out_value, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, event_kind, out_channel, out_note, out_velocity, out_controller,
           out_value, last_of_run,
    output ready
  );
endinterface

// ----- rtl/core/mrt_front.sv -----
// Front end: accepts input transfers, decodes action and status kind into a command.
// Depends on mrt_pkg and mrt_msg_if.
module mrt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mrt_msg_if.sink       msg_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mrt_pkg::cmd_t cmd_o
);
  import mrt_pkg::*;

  logic       valid_q, valid_d;
  cmd_t       cmd_q, cmd_d;
  cmd_t       dec;
  logic       kind_ok;
  logic [7:0] kind_bits;
  logic [7:0] chan_bits;
  logic       accept;

  assign msg_i.ready = !valid_q || cmd_ready_i;
  assign accept      = msg_i.valid && msg_i.ready;

  always_comb begin
    kind_bits     = msg_i.msg_status & STATUS_KIND_MASK;
    chan_bits     = msg_i.msg_status & STATUS_CHAN_MASK;
    dec.kind      = KIND_NOTE_ON;
    kind_ok       = 1'b1;
    case (kind_bits)
      STATUS_NOTE_ON:  dec.kind = KIND_NOTE_ON;
      STATUS_NOTE_OFF: dec.kind = KIND_NOTE_OFF;
      STATUS_CONTROL:  dec.kind = KIND_CONTROL;
      STATUS_PROGRAM:  dec.kind = KIND_PROGRAM;
      STATUS_BEND:     dec.kind = KIND_BEND;
      default:         kind_ok  = 1'b0;
    endcase
    // Messages of an unknown kind and the unused action never reach the back end.
    case (msg_i.action)
      ACT_ROUTE:  dec.op = kind_ok ? OP_ROUTE : OP_NONE;
      ACT_ADD:    dec.op = OP_ADD;
      ACT_REMOVE: dec.op = OP_REMOVE;
      default:    dec.op = OP_NONE;
    endcase
    dec.chan      = chan_bits[3:0];
    dec.d1        = msg_i.msg_data1;
    dec.d2        = msg_i.msg_data2;
    dec.track     = msg_i.track_id;
    dec.in_ch     = $unsigned(msg_i.new_in_channel);
    dec.out_ch    = msg_i.new_out_channel;
    dec.transpose = $unsigned(msg_i.new_transpose);
    dec.min_note  = msg_i.new_min_note;
    dec.max_note  = msg_i.new_max_note;
    dec.gain      = msg_i.new_velocity_gain;
  end

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && cmd_ready_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = (dec.op != OP_NONE);
      cmd_d   = dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

// ----- rtl/core/mrt_queue.sv -----
// Two-entry command queue between the front end and the route engine.
// Depends on mrt_pkg for the command type.
module mrt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mrt_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mrt_pkg::cmd_t pop_cmd_o
);
  import mrt_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/core/mrt_back.sv -----
// Route engine: holds the route table, applies adds and removes, walks the table
// for messages, one entry a cycle unless stalled. Depends on mrt_pkg, mrt_res_if.
module mrt_back #(
  parameter int unsigned ROUTE_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mrt_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  mrt_pkg::cmd_t                 cmd_i,
  mrt_res_if.source                     res_o
);
  import mrt_pkg::*;

  localparam int unsigned IdxW = (ROUTE_COUNT > 1) ? $clog2(ROUTE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ROUTE_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  // Route table.
  logic [ROUTE_COUNT-1:0] en_q;
  logic [7:0]  track_q     [ROUTE_COUNT];
  logic [4:0]  in_ch_q     [ROUTE_COUNT];
  logic [3:0]  out_ch_q    [ROUTE_COUNT];
  logic [7:0]  transpose_q [ROUTE_COUNT];
  logic [6:0]  min_q       [ROUTE_COUNT];
  logic [6:0]  max_q       [ROUTE_COUNT];
  logic [15:0] gain_q      [ROUTE_COUNT];

  // Sequencer.
  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [LIMIT_W-1:0] count_q, count_d;
  cmd_t            cur_q, cur_d;
  logic            hold_valid_q, hold_valid_d;
  res_t            hold_q, hold_d;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;

  logic                   pop, add_we, rem_we;
  logic [ROUTE_COUNT-1:0] hit_first, free_first, add_sel;
  logic                   hit_any, free_any;

  // First matching track and first disabled entry.
  always_comb begin
    hit_first  = '0;
    free_first = '0;
    hit_any    = 1'b0;
    free_any   = 1'b0;
    for (int i = 0; i < ROUTE_COUNT; i++) begin
      if (!hit_any && track_q[i] == cmd_i.track) begin
        hit_first[i] = 1'b1;
        hit_any      = 1'b1;
      end
      if (!free_any && !en_q[i]) begin
        free_first[i] = 1'b1;
        free_any      = 1'b1;
      end
    end
    add_sel = hit_any ? hit_first : free_first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        track_q[i]     <= 8'd0;
        in_ch_q[i]     <= IN_CH_ANY;
        out_ch_q[i]    <= 4'd0;
        transpose_q[i] <= 8'd0;
        min_q[i]       <= 7'd0;
        max_q[i]       <= NOTE_MAX;
        gain_q[i]      <= GAIN_UNITY;
      end
    end else begin
      for (int i = 0; i < ROUTE_COUNT; i++) begin
        if (add_we && add_sel[i]) begin
          en_q[i]        <= 1'b1;
          track_q[i]     <= cmd_i.track;
          in_ch_q[i]     <= cmd_i.in_ch;
          out_ch_q[i]    <= cmd_i.out_ch;
          transpose_q[i] <= cmd_i.transpose;
          min_q[i]       <= cmd_i.min_note;
          max_q[i]       <= cmd_i.max_note;
          gain_q[i]      <= cmd_i.gain;
        end else if (rem_we && hit_first[i]) begin
          en_q[i] <= 1'b0;
        end
      end
    end
  end

  // Remap of the current message through the entry under the walk index.
  logic [4:0]        e_in;
  logic [7:0]        e_tr;
  logic signed [8:0] note_sum;
  logic              range_ok, chan_ok, kind_emit, emit;
  logic [22:0]       prod;
  logic [14:0]       vel_raw;
  logic [6:0]        vel;
  res_t              cand;

  always_comb begin
    e_in     = in_ch_q[idx_q];
    e_tr     = transpose_q[idx_q];
    chan_ok  = (e_in == IN_CH_ANY) || (e_in == {1'b0, cur_q.chan});
    note_sum = $signed({2'b00, cur_q.d1}) + $signed({e_tr[7], e_tr});
    range_ok = (note_sum >= $signed({2'b00, min_q[idx_q]}))
            && (note_sum <= $signed({2'b00, max_q[idx_q]}));
    prod     = 23'(cur_q.d2) * 23'(gain_q[idx_q]);
    vel_raw  = prod[22:8];
    vel      = (|vel_raw[14:7]) ? NOTE_MAX : vel_raw[6:0];

    cand             = '0;
    cand.out_channel = out_ch_q[idx_q];
    kind_emit        = 1'b1;
    case (cur_q.kind)
      KIND_NOTE_ON: begin
        kind_emit         = range_ok;
        cand.out_note     = note_sum[6:0];
        cand.out_velocity = vel;
        cand.event_kind   = (vel == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
      end
      KIND_NOTE_OFF: begin
        kind_emit       = range_ok;
        cand.out_note   = note_sum[6:0];
        cand.event_kind = EV_NOTE_OFF;
      end
      KIND_CONTROL: begin
        cand.event_kind     = EV_CONTROL;
        cand.out_controller = cur_q.d1;
        cand.out_value      = {7'd0, cur_q.d2};
      end
      KIND_PROGRAM: begin
        cand.event_kind = EV_PROGRAM;
        cand.out_value  = {7'd0, cur_q.d1};
      end
      KIND_BEND: begin
        cand.event_kind = EV_BEND;
        cand.out_value  = {cur_q.d2, cur_q.d1};
      end
      default: kind_emit = 1'b0;
    endcase
    emit = en_q[idx_q] && chan_ok && kind_emit && (count_q < limit_i);
  end

  // One result is held back until the next one or the end of the walk shows
  // whether it is the last of its run.
  logic out_free;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    cur_d        = cur_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pop          = 1'b0;
    add_we       = 1'b0;
    rem_we       = 1'b0;
    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          pop = 1'b1;
          case (cmd_i.op)
            OP_ROUTE: begin
              cur_d   = cmd_i;
              idx_d   = '0;
              count_d = '0;
              state_d = S_WALK;
            end
            OP_ADD:    add_we = hit_any || free_any;
            OP_REMOVE: rem_we = hit_any;
            default:   ;
          endcase
        end
      end
      S_WALK: begin
        if (!(emit && hold_valid_q && !out_free)) begin
          if (emit) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = hold_q;
            end
            hold_d       = cand;
            hold_valid_d = 1'b1;
            count_d      = count_q + LIMIT_W'(1);
          end
          if (idx_q == LastIdx) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = hold_q;
          out_d.last_of_run = 1'b1;
          hold_valid_d      = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      cur_q        <= '0;
      hold_valid_q <= 1'b0;
      hold_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      cur_q        <= cur_d;
      hold_valid_q <= hold_valid_d;
      hold_q       <= hold_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign cmd_ready_o          = pop;
  assign res_o.valid          = out_valid_q;
  assign res_o.event_kind     = out_q.event_kind;
  assign res_o.out_channel    = out_q.out_channel;
  assign res_o.out_note       = out_q.out_note;
  assign res_o.out_velocity   = out_q.out_velocity;
  assign res_o.out_controller = out_q.out_controller;
  assign res_o.out_value      = out_q.out_value;
  assign res_o.last_of_run    = out_q.last_of_run;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_RESULTS)
    else $error("result count above the maximum");
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_valid_q)
    else $error("held result left behind at end of walk");
  a_hold_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> count_q != '0)
    else $error("held result not counted");
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && hold_valid_q && out_free) |=> (out_valid_q && out_q.last_of_run))
    else $error("final result not flagged as last of run");
`endif

endmodule

// ----- rtl/core/midi_route_table_mapper.sv -----
// Top level of the MIDI route table mapper: configuration register and the
// front end, command queue and route engine. Depends on mrt_pkg and mrt_if.
// Usage. Items arrive on msg_i as valid/ready transfers. Action route sends a
// MIDI message through the table, add writes a route (replacing the entry of
// the same track, else the first disabled one), remove disables a track's
// route. Results leave on res_o as valid/ready transfers; last_of_run marks
// the final result of a message. A message that yields nothing produces no
// transfer at all.
// Timing. The front end registers and decodes each item and the two-entry
// queue lets it keep taking items while the engine is busy. Add and remove
// are applied in the idle state as they are popped. A message walks the table
// one entry per cycle unless the walk pauses for the output register (below);
// each result is held back in a hold register so that the last can be flagged.
// When the receiver stalls, the output register holds its result and the
// walk pauses only when a further result needs that register.
// Reset clears the table to all routes disabled (track 0, any channel, full
// note range, unity gain) and sets output_limit to 8. Write output_limit via
// cfg_we_i only while no message is in flight; values above 8 act as 8.
module midi_route_table_mapper #(
  parameter int unsigned ROUTE_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  mrt_msg_if.sink    msg_i,
  mrt_res_if.source  res_o
);
  import mrt_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] limit_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // The engine never emits more than eight results for one message.
  assign limit_eff = (limit_q > MAX_RESULTS) ? MAX_RESULTS : limit_q;

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  mrt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .msg_i       (msg_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  mrt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  mrt_back #(
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_eff),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_o       (res_o)
  );

endmodule

// ----- verif/tb_midi_route_table_mapper.sv -----
// Self-checking testbench for midi_route_table_mapper: a route table model predicts
// every result, which is then compared with what the block emits. Handshakes stall at random.
// Depends on mrt_pkg, the mrt_msg_if and mrt_res_if interfaces and the block itself.
module tb_midi_route_table_mapper;
  import mrt_pkg::*;

  localparam int ROUTES        = 8;
  // Deadline for the whole run.
  localparam int CYCLE_LIMIT   = 400_000;
  // Cycles allowed after the last expected result before the block is taken to be idle.
  // Up to four messages that emit nothing can still sit in the front end, the queue
  // and the engine.
  localparam int SETTLE_CYCLES = 64;
  localparam int CHUNK_ITEMS   = 60;

  // The action code that the block must ignore has no name in the package.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One input item, field for field as the message channel carries it. The in-channel
  // filter is held as raw five-bit two's complement.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  msg_status;
    logic [6:0]  msg_data1;
    logic [6:0]  msg_data2;
    logic [7:0]  track_id;
    logic [4:0]  new_in_channel;
    logic [3:0]  new_out_channel;
    logic [7:0]  new_transpose;
    logic [6:0]  new_min_note;
    logic [6:0]  new_max_note;
    logic [15:0] new_velocity_gain;
  } msg_item_t;

  // Model of the route table. It keeps its own copy of every entry and of the output
  // limit, works out the results of each accepted item and holds them until they arrive.
  class route_table_model;
    logic        enabled [ROUTES];
    logic [7:0]  track [ROUTES];
    logic [4:0]  in_chan [ROUTES];
    logic [3:0]  out_chan [ROUTES];
    logic [7:0]  transpose [ROUTES];
    logic [6:0]  low_note [ROUTES];
    logic [6:0]  high_note [ROUTES];
    logic [15:0] gain [ROUTES];
    logic [3:0]  limit;
    res_t        expected_events[$];
    int          errors;

    function new();
      limit  = LIMIT_RESET;
      errors = 0;
      for (int i = 0; i < ROUTES; i++) begin
        enabled[i]   = 1'b0;
        track[i]     = '0;
        in_chan[i]   = IN_CH_ANY;
        out_chan[i]  = '0;
        transpose[i] = '0;
        low_note[i]  = '0;
        high_note[i] = NOTE_MAX;
        gain[i]      = GAIN_UNITY;
      end
    endfunction

    // Queues one result per matching enabled entry, in index order, up to the output limit.
    function void map_message(msg_item_t it);
      logic [7:0] kind;
      logic [3:0] chan;
      int         cap;
      int         shift;
      int         note;
      int         vel;
      res_t       ev;
      res_t       run[$];
      kind = it.msg_status & STATUS_KIND_MASK;
      chan = it.msg_status[3:0];
      cap  = (limit > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(limit);
      for (int i = 0; i < ROUTES; i++) begin
        if (!enabled[i]) continue;
        if (in_chan[i] != IN_CH_ANY && in_chan[i] != {1'b0, chan}) continue;
        if (run.size() >= cap) break;
        ev = '0;
        ev.out_channel = out_chan[i];
        case (kind)
          STATUS_NOTE_ON, STATUS_NOTE_OFF: begin
            shift = int'($signed(transpose[i]));
            note  = int'(it.msg_data1) + shift;
            if (note < int'(low_note[i]) || note > int'(high_note[i])) continue;
            ev.out_note = note[6:0];
            if (kind == STATUS_NOTE_ON) begin
              // Q8.8 scale, truncated, then clamped; a zero velocity becomes a note off.
              vel = (int'(it.msg_data2) * int'(gain[i])) >> 8;
              if (vel > int'(NOTE_MAX)) vel = int'(NOTE_MAX);
              ev.out_velocity = vel[6:0];
              ev.event_kind   = (vel == 0) ? EV_NOTE_OFF : EV_NOTE_ON;
            end else begin
              ev.event_kind = EV_NOTE_OFF;
            end
          end
          STATUS_CONTROL: begin
            ev.event_kind     = EV_CONTROL;
            ev.out_controller = it.msg_data1;
            ev.out_value      = {7'd0, it.msg_data2};
          end
          STATUS_PROGRAM: begin
            ev.event_kind = EV_PROGRAM;
            ev.out_value  = {7'd0, it.msg_data1};
          end
          STATUS_BEND: begin
            ev.event_kind = EV_BEND;
            ev.out_value  = {it.msg_data2, it.msg_data1};
          end
          default: continue;
        endcase
        run.push_back(ev);
      end
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[k]) expected_events.push_back(run[k]);
    endfunction

    // Updates the table for an accepted item and queues the results of a message.
    function void note_item(msg_item_t it);
      int slot;
      slot = -1;
      case (it.action)
        ACT_ADD: begin
          // The entry of the same track wins, enabled or not; else the first free one.
          for (int i = 0; i < ROUTES && slot < 0; i++)
            if (track[i] == it.track_id) slot = i;
          for (int i = 0; i < ROUTES && slot < 0; i++)
            if (!enabled[i]) slot = i;
          if (slot >= 0) begin
            enabled[slot]   = 1'b1;
            track[slot]     = it.track_id;
            in_chan[slot]   = it.new_in_channel;
            out_chan[slot]  = it.new_out_channel;
            transpose[slot] = it.new_transpose;
            low_note[slot]  = it.new_min_note;
            high_note[slot] = it.new_max_note;
            gain[slot]      = it.new_velocity_gain;
          end
        end
        ACT_REMOVE: begin
          for (int i = 0; i < ROUTES && slot < 0; i++)
            if (track[i] == it.track_id) slot = i;
          if (slot >= 0) enabled[slot] = 1'b0;
        end
        ACT_ROUTE: map_message(it);
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        errors++;
      end
    endfunction

    // Compares a result taken from the block with the oldest one still expected.
    function void check_event(res_t got);
      res_t want;
      if (expected_events.size() == 0) begin
        $error("result with none expected: event_kind %0d, out_channel %0d, out_note %0d",
               got.event_kind, got.out_channel, got.out_note);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
      compare_field("out_channel", 16'(want.out_channel), 16'(got.out_channel));
      compare_field("out_note", 16'(want.out_note), 16'(got.out_note));
      compare_field("out_velocity", 16'(want.out_velocity), 16'(got.out_velocity));
      compare_field("out_controller", 16'(want.out_controller), 16'(got.out_controller));
      compare_field("out_value", 16'(want.out_value), 16'(got.out_value));
      compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  mrt_msg_if msg_bus ();
  mrt_res_if res_bus ();

  route_table_model table_model = new();

  // Idling odds in percent per cycle for each side, and a request from the stimulus
  // for the receiver to hold off for a number of cycles.
  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int cycle_count;

  midi_route_table_mapper #(
    .ROUTE_COUNT (ROUTES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .msg_i       (msg_bus),
    .res_o       (res_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Builds a MIDI message item; the route fields are left at zero as the block ignores them.
  function automatic msg_item_t route_msg(logic [7:0] status, logic [6:0] d1, logic [6:0] d2);
    msg_item_t it;
    it            = '0;
    it.action     = ACT_ROUTE;
    it.msg_status = status;
    it.msg_data1  = d1;
    it.msg_data2  = d2;
    return it;
  endfunction

  // Builds an add, remove or unused item carrying a full set of route settings.
  function automatic msg_item_t route_cmd(logic [1:0] act, logic [7:0] trk, logic [4:0] in_ch,
                                          logic [3:0] out_ch, logic [7:0] shift,
                                          logic [6:0] lo, logic [6:0] hi, logic [15:0] g);
    msg_item_t it;
    it                   = '0;
    it.action            = act;
    it.track_id          = trk;
    it.new_in_channel    = in_ch;
    it.new_out_channel   = out_ch;
    it.new_transpose     = shift;
    it.new_min_note      = lo;
    it.new_max_note      = hi;
    it.new_velocity_gain = g;
    return it;
  endfunction

  // Random item. Tracks come mostly from a small pool so that adds replace entries,
  // removes hit, and the table fills up; channels and filters are kept close so that
  // messages find routes. Every field still reaches its full range now and then.
  function automatic msg_item_t random_item();
    msg_item_t  it;
    int         pick;
    logic [7:0] kinds [6] = '{STATUS_NOTE_OFF, STATUS_NOTE_ON, STATUS_NOTE_ON,
                              STATUS_CONTROL, STATUS_PROGRAM, STATUS_BEND};
    it.msg_status        = 8'($urandom);
    it.msg_data1         = 7'($urandom);
    it.msg_data2         = 7'($urandom);
    it.new_out_channel   = 4'($urandom);
    it.new_transpose     = 8'($urandom);
    it.new_min_note      = 7'($urandom);
    it.new_max_note      = 7'($urandom);
    it.new_velocity_gain = 16'($urandom);
    it.new_in_channel    = 5'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 22)      it.action = ACT_ADD;
    else if (pick < 32) it.action = ACT_REMOVE;
    else if (pick < 96) it.action = ACT_ROUTE;
    else                it.action = ACT_UNUSED;

    it.track_id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 11)) : 8'($urandom);

    pick = $urandom_range(0, 99);
    if (pick < 40)      it.new_in_channel = IN_CH_ANY;
    else if (pick < 80) it.new_in_channel = 5'($urandom_range(0, 3));
    else if (pick < 92) it.new_in_channel = 5'($urandom_range(0, 15));
    // Otherwise a negative filter other than any channel, which matches nothing.
    else                it.new_in_channel = 5'($urandom_range(16, 30));

    if ($urandom_range(0, 99) < 70) it.new_transpose = 8'($urandom_range(0, 24) - 12);
    if ($urandom_range(0, 99) < 75) begin
      it.new_min_note = 7'($urandom_range(0, 40));
      it.new_max_note = 7'($urandom_range(80, 127));
    end

    pick = $urandom_range(0, 99);
    if (pick < 35)      it.new_velocity_gain = GAIN_UNITY;
    else if (pick < 70) it.new_velocity_gain = 16'($urandom_range(0, 600));

    if ($urandom_range(0, 99) < 85)
      it.msg_status = kinds[$urandom_range(0, 5)] |
                      (($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(0, 15)));
    return it;
  endfunction

  // Offers one item and returns at the edge of its transfer, with valid still high so
  // that a following item can go out back to back.
  task automatic send_item(input msg_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      msg_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_bus.valid             <= 1'b1;
    msg_bus.action            <= it.action;
    msg_bus.msg_status        <= it.msg_status;
    msg_bus.msg_data1         <= it.msg_data1;
    msg_bus.msg_data2         <= it.msg_data2;
    msg_bus.track_id          <= it.track_id;
    msg_bus.new_in_channel    <= it.new_in_channel;
    msg_bus.new_out_channel   <= it.new_out_channel;
    msg_bus.new_transpose     <= it.new_transpose;
    msg_bus.new_min_note      <= it.new_min_note;
    msg_bus.new_max_note      <= it.new_max_note;
    msg_bus.new_velocity_gain <= it.new_velocity_gain;
    do @(posedge clk_i); while (!msg_bus.ready);
    table_model.note_item(it);
  endtask

  // Waits for every expected result, then lets the block finish items that emit nothing.
  task automatic settle();
    while (table_model.expected_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The output limit is only written once the block has gone quiet.
  task automatic program_limit(input logic [3:0] value);
    msg_bus.valid <= 1'b0;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    table_model.limit = value;
  endtask

  // Stimulus: reset, a directed opening, then six random chunks, each under its own
  // output limit. The idling pattern changes every two chunks.
  initial begin
    msg_item_t  opening[$];
    logic [3:0] chunk_limit [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8};

    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    msg_bus.valid <= 1'b0;
    msg_bus.action            <= ACT_ROUTE;
    msg_bus.msg_status        <= '0;
    msg_bus.msg_data1         <= '0;
    msg_bus.msg_data2         <= '0;
    msg_bus.track_id          <= '0;
    msg_bus.new_in_channel    <= '0;
    msg_bus.new_out_channel   <= '0;
    msg_bus.new_transpose     <= '0;
    msg_bus.new_min_note      <= '0;
    msg_bus.new_max_note      <= '0;
    msg_bus.new_velocity_gain <= '0;
    send_idle_pct = 32;
    recv_idle_pct = 88;
    stall_request = 0;

    // A message to the empty table emits nothing, and a remove of track 0 lands on
    // entry 0, since every entry holds track 0 after reset.
    opening.push_back(route_msg(STATUS_NOTE_ON, 7'd60, 7'd100));
    opening.push_back(route_cmd(ACT_REMOVE, 8'd0, IN_CH_ANY, 4'd0, 8'd0, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    // Routes: any channel; channel 3 with a narrow range and double gain; a negative
    // filter that matches nothing; a transpose of -127 with the largest gain; and a
    // range with its minimum above its maximum, which drops every note.
    opening.push_back(route_cmd(ACT_ADD, 8'd0, IN_CH_ANY, 4'd5, 8'd0, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    opening.push_back(route_cmd(ACT_ADD, 8'd1, 5'd3, 4'd15, 8'd12, 7'd60, 7'd72, 16'd512));
    opening.push_back(route_cmd(ACT_ADD, 8'd2, 5'h1E, 4'd1, 8'd0, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    opening.push_back(route_cmd(ACT_ADD, 8'd3, IN_CH_ANY, 4'd0, 8'h81, 7'd0, NOTE_MAX,
                                16'hFFFF));
    opening.push_back(route_cmd(ACT_ADD, 8'd4, 5'd0, 4'd9, 8'd127, 7'd100, 7'd50, 16'd0));
    // Every message kind, a clamped velocity, a zero velocity turned into a note off,
    // the extremes of the data bytes, and statuses that must emit nothing.
    opening.push_back(route_msg(STATUS_NOTE_ON | 8'd3, 7'd60, 7'd127));
    opening.push_back(route_msg(STATUS_NOTE_ON | 8'd3, 7'd60, 7'd0));
    opening.push_back(route_msg(STATUS_NOTE_OFF | 8'd3, 7'd127, 7'd100));
    opening.push_back(route_msg(STATUS_CONTROL | 8'd3, 7'd127, 7'd127));
    opening.push_back(route_msg(STATUS_PROGRAM, 7'd0, 7'd0));
    opening.push_back(route_msg(STATUS_BEND | 8'd15, 7'd127, 7'd127));
    opening.push_back(route_msg(8'hA3, 7'd60, 7'd60));
    opening.push_back(route_msg(8'h45, 7'd1, 7'd2));
    // Replacing track 0 in place with the most negative transpose and a tiny gain.
    opening.push_back(route_cmd(ACT_ADD, 8'd0, 5'd3, 4'd2, 8'h80, 7'd0, NOTE_MAX, 16'd1));
    opening.push_back(route_msg(STATUS_NOTE_ON | 8'd3, 7'd127, 7'd127));
    opening.push_back(route_msg(STATUS_NOTE_ON | 8'd3, 7'd127, 7'd3));
    // Fill the table, then an add with no match and no free entry changes nothing.
    opening.push_back(route_cmd(ACT_ADD, 8'd5, IN_CH_ANY, 4'd10, 8'd1, 7'd0, NOTE_MAX,
                                16'd384));
    opening.push_back(route_cmd(ACT_ADD, 8'd6, 5'd0, 4'd11, 8'hFF, 7'd0, NOTE_MAX, 16'd128));
    opening.push_back(route_cmd(ACT_ADD, 8'd7, IN_CH_ANY, 4'd12, 8'd0, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    opening.push_back(route_cmd(ACT_ADD, 8'd255, IN_CH_ANY, 4'd13, 8'd0, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    // Free entry 2 and take it again with a new track; the unused action is ignored.
    opening.push_back(route_cmd(ACT_REMOVE, 8'd2, 5'd0, 4'd0, 8'd0, 7'd0, 7'd0, 16'd0));
    opening.push_back(route_cmd(ACT_ADD, 8'd9, IN_CH_ANY, 4'd14, 8'd2, 7'd0, NOTE_MAX,
                                GAIN_UNITY));
    opening.push_back(route_cmd(ACT_UNUSED, 8'd1, IN_CH_ANY, 4'd0, 8'd0, 7'd0, 7'd0, 16'd0));
    opening.push_back(route_msg(STATUS_NOTE_ON, 7'd64, 7'd64));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[k]) send_item(opening[k]);

    for (int c = 0; c < 6; c++) begin
      // The first pair of chunks starves the receiver, the second the sender, and the
      // last pair runs both sides flat out.
      case (c / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_limit(chunk_limit[c]);
      // In the last chunk the receiver holds off for a long stretch while items keep
      // coming, so that the queue fills up and the block stops taking input.
      if (c == 5) stall_request = 300;
      for (int k = 0; k < CHUNK_ITEMS; k++) send_item(random_item());
    end

    msg_bus.valid <= 1'b0;
    settle();
    if (table_model.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: checks each transfer and decides the next cycle's ready, taking on any
  // hold-off that the stimulus asks for and counting it down here.
  initial begin
    res_t got;
    int   hold_left;
    hold_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        got.event_kind     = res_bus.event_kind;
        got.out_channel    = res_bus.out_channel;
        got.out_note       = res_bus.out_note;
        got.out_velocity   = res_bus.out_velocity;
        got.out_controller = res_bus.out_controller;
        got.out_value      = res_bus.out_value;
        got.last_of_run    = res_bus.last_of_run;
        table_model.check_event(got);
      end
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a run that has not ended by the deadline has hung somewhere.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
